>>> rtl/duration_string_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Duration string parser assertion macros
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DURATION_STRING_PARSER_CORE_MACROS_SVH
`define DURATION_STRING_PARSER_CORE_MACROS_SVH

`define DSP_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

`define DSP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// Duration string parser package
// Character classes, scale codes, queue entry and constant tables.
// ----------------------------------------------------------------------------
package dsp_pkg;

    localparam int MAX_FRAC_DIGITS = 19;
    localparam int MUL_W           = 30;

    localparam logic [MUL_W-1:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [MUL_W-1:0] SEC_PER_MIN  = 30'd60;
    localparam logic [MUL_W-1:0] SEC_PER_HOUR = 30'd3600;
    localparam logic [MUL_W-1:0] SEC_PER_DAY  = 30'd86400;
    localparam logic [MUL_W-1:0] SCALE_UNIT   = 30'd1;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_DIGIT,
        CL_DOT,
        CL_SUFFIX,
        CL_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        FAC_ONE,
        FAC_MIN,
        FAC_HOUR,
        FAC_DAY
    } scale_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        scale_t      fac;
        logic        tend;
        logic        lend;
    } q_entry_t;

    function automatic logic [MUL_W-1:0] scale_factor(input scale_t f);
        logic [MUL_W-1:0] v;
        unique case (f)
            FAC_MIN:  v = SEC_PER_MIN;
            FAC_HOUR: v = SEC_PER_HOUR;
            FAC_DAY:  v = SEC_PER_DAY;
            default:  v = SCALE_UNIT;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] pow10(input logic [4:0] n);
        logic [63:0] v;
        case (n)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd10;
            5'd2:    v = 64'd100;
            5'd3:    v = 64'd1000;
            5'd4:    v = 64'd10000;
            5'd5:    v = 64'd100000;
            5'd6:    v = 64'd1000000;
            5'd7:    v = 64'd10000000;
            5'd8:    v = 64'd100000000;
            5'd9:    v = 64'd1000000000;
            5'd10:   v = 64'd10000000000;
            5'd11:   v = 64'd100000000000;
            5'd12:   v = 64'd1000000000000;
            5'd13:   v = 64'd10000000000000;
            5'd14:   v = 64'd100000000000000;
            5'd15:   v = 64'd1000000000000000;
            5'd16:   v = 64'd10000000000000000;
            5'd17:   v = 64'd100000000000000000;
            5'd18:   v = 64'd1000000000000000000;
            default: v = 64'd10000000000000000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/dsp_front.sv
// ----------------------------------------------------------------------------
// Duration string parser front end
// Accepts character beats, classifies them and hands entries to the queue.
// ----------------------------------------------------------------------------
module dsp_front import dsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic [0:0] s_tuser,
    output logic       push_valid,
    input  logic       push_ready,
    output q_entry_t   push_data
);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_D    = 8'h64;

    logic     hold_valid_reg, hold_valid_next;
    q_entry_t hold_reg, hold_next;
    q_entry_t entry_new;
    logic     accept;
    logic     keep;

    always_comb begin
        entry_new.cls   = CL_OTHER;
        entry_new.digit = s_tdata[3:0];
        entry_new.fac   = FAC_ONE;
        entry_new.tend  = s_tlast;
        entry_new.lend  = s_tuser[0];
        if (s_tdata == CH_NUL) begin
            entry_new.cls = CL_NONE;
        end else if (s_tdata >= CH_ZERO && s_tdata <= CH_NINE) begin
            entry_new.cls = CL_DIGIT;
        end else begin
            unique case (s_tdata)
                CH_DOT: entry_new.cls = CL_DOT;
                CH_S: begin
                    entry_new.cls = CL_SUFFIX;
                end
                CH_M: begin
                    entry_new.cls = CL_SUFFIX;
                    entry_new.fac = FAC_MIN;
                end
                CH_H: begin
                    entry_new.cls = CL_SUFFIX;
                    entry_new.fac = FAC_HOUR;
                end
                CH_D: begin
                    entry_new.cls = CL_SUFFIX;
                    entry_new.fac = FAC_DAY;
                end
                default: entry_new.cls = CL_OTHER;
            endcase
        end
    end

    // drop empty beats that do not close a token
    assign keep     = (entry_new.cls != CL_NONE) || s_tlast;
    assign s_tready = !hold_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        hold_next = hold_reg;
        if (accept) begin
            hold_valid_next = keep;
            hold_next       = entry_new;
        end else if (push_ready) begin
            hold_valid_next = 1'b0;
        end else begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

    assign push_valid = hold_valid_reg;
    assign push_data  = hold_reg;

endmodule

>>> rtl/dsp_fifo.sv
// ----------------------------------------------------------------------------
// Duration string parser entry queue
// Short FIFO between classifier and execution back end.
// ----------------------------------------------------------------------------
module dsp_fifo import dsp_pkg::*; #(
    parameter  int DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  q_entry_t         wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output q_entry_t         rd_data,
    output logic [CNT_W-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_fire, rd_fire;

    assign wr_ready = count_reg != CNT_FULL;
    assign rd_valid = count_reg != '0;
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/dsp_div.sv
// ----------------------------------------------------------------------------
// Duration string parser divider
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsp_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    localparam int W     = 64;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(W);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     div_reg, div_next;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;

    assign shifted = {rem_reg, quot_reg[W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_START;
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[W-2:0], ge};
            rem_next  = ge ? diff[W-1:0] : shifted[W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> rtl/dsp_back.sv
// ----------------------------------------------------------------------------
// Duration string parser back end
// Parse state, scaling multiplier, token close and result register.
// ----------------------------------------------------------------------------
module dsp_back import dsp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  q_entry_t    pop_data,
    output logic        div_start,
    output logic [63:0] div_dividend,
    output logic [63:0] div_divisor,
    input  logic        div_done,
    input  logic [63:0] div_quot,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] token_nanos,
    output logic [63:0] total_nanos,
    output logic        invalid,
    output logic        is_final
);

    localparam int PROD_W = 32 + MUL_W;
    localparam logic [1:0] PH_INT  = 2'd0;
    localparam logic [1:0] PH_FRAC = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [4:0] FRAC_LIMIT = 5'(MAX_FRAC_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_ADD,
        S_END,
        S_DIV,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [63:0]        acc_reg, acc_next;
    logic [4:0]         frac_reg, frac_next;
    logic [1:0]         phase_reg, phase_next;
    logic               bad_reg, bad_next;
    logic [63:0]        total_reg, total_next;
    logic [MUL_W-1:0]   mul_b_reg, mul_b_next;
    scale_t             fac_reg, fac_next;
    logic               tend_reg, tend_next;
    logic               lend_reg, lend_next;
    logic [PROD_W-1:0]  p_reg, p_next;
    logic [31:0]        q_reg, q_next;
    logic [63:0]        nanos_reg, nanos_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        tok_reg, tok_next;
    logic [63:0]        tot_reg, tot_next;
    logic               inv_reg, inv_next;
    logic               fin_reg, fin_next;

    logic [31:0]        mul_a;
    logic [PROD_W-1:0]  prod;
    logic [63:0]        acc_digit;
    logic [63:0]        sum;
    logic               need_mul;
    logic               open_phase;

    assign mul_a     = (state_reg == S_MUL_LO) ? acc_reg[31:0] : acc_reg[63:32];
    assign prod      = {{MUL_W{1'b0}}, mul_a} * {32'd0, mul_b_reg};
    assign acc_digit = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                     + {60'd0, pop_data.digit};
    assign sum        = total_reg + nanos_reg;
    assign open_phase = (phase_reg == PH_INT) || (phase_reg == PH_FRAC);

    assign pop_ready    = state_reg == S_IDLE;
    assign div_start    = (state_reg == S_END) && (frac_reg != '0);
    assign div_dividend = acc_reg;
    assign div_divisor  = pow10(frac_reg);

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        frac_next      = frac_reg;
        phase_next     = phase_reg;
        bad_next       = bad_reg;
        total_next     = total_reg;
        mul_b_next     = mul_b_reg;
        fac_next       = fac_reg;
        tend_next      = tend_reg;
        lend_next      = lend_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        nanos_next     = nanos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        tok_next       = tok_reg;
        tot_next       = tot_reg;
        inv_next       = inv_reg;
        fin_next       = fin_reg;
        need_mul       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    tend_next = pop_data.tend;
                    lend_next = pop_data.lend;
                    fac_next  = FAC_ONE;
                    if (pop_data.cls != CL_NONE) begin
                        if (!open_phase) begin
                            bad_next = 1'b1;
                        end else begin
                            unique case (pop_data.cls)
                                CL_DIGIT: begin
                                    if (phase_reg == PH_INT) begin
                                        acc_next = acc_digit;
                                    end else if (frac_reg < FRAC_LIMIT) begin
                                        acc_next  = acc_digit;
                                        frac_next = frac_reg + 1'b1;
                                    end else begin
                                        bad_next = 1'b1;
                                    end
                                end
                                CL_DOT: begin
                                    if (phase_reg == PH_INT) begin
                                        phase_next = PH_FRAC;
                                    end else begin
                                        bad_next   = 1'b1;
                                        need_mul   = 1'b1;
                                        phase_next = PH_DONE;
                                    end
                                end
                                CL_SUFFIX: begin
                                    need_mul   = 1'b1;
                                    phase_next = PH_DONE;
                                    fac_next   = pop_data.fac;
                                end
                                default: begin
                                    bad_next   = 1'b1;
                                    need_mul   = 1'b1;
                                    phase_next = PH_DONE;
                                end
                            endcase
                        end
                    end
                    // no suffix at token close: count as seconds
                    if (pop_data.tend && (phase_next == PH_INT || phase_next == PH_FRAC)) begin
                        need_mul = 1'b1;
                    end
                    mul_b_next = NS_PER_SEC;
                    if (need_mul) begin
                        state_next = S_MUL_LO;
                    end else if (pop_data.tend) begin
                        state_next = S_END;
                    end
                end
            end
            S_MUL_LO: begin
                p_next     = prod;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                q_next     = prod[31:0];
                state_next = S_MUL_ADD;
            end
            S_MUL_ADD: begin
                acc_next = {{(64 - PROD_W){1'b0}}, p_reg} + {q_reg, 32'd0};
                if (fac_reg != FAC_ONE) begin
                    mul_b_next = scale_factor(fac_reg);
                    fac_next   = FAC_ONE;
                    state_next = S_MUL_LO;
                end else if (tend_reg) begin
                    state_next = S_END;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_END: begin
                if (frac_reg == '0) begin
                    nanos_next = acc_reg;
                    state_next = S_OUT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    nanos_next = div_quot;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    tok_next       = nanos_reg;
                    tot_next       = sum;
                    inv_next       = bad_reg;
                    fin_next       = lend_reg;
                    total_next     = lend_reg ? '0 : sum;
                    acc_next       = '0;
                    frac_next      = '0;
                    phase_next     = PH_INT;
                    bad_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            frac_reg      <= '0;
            phase_reg     <= PH_INT;
            bad_reg       <= 1'b0;
            total_reg     <= '0;
            fac_reg       <= FAC_ONE;
            tend_reg      <= 1'b0;
            lend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            frac_reg      <= frac_next;
            phase_reg     <= phase_next;
            bad_reg       <= bad_next;
            total_reg     <= total_next;
            fac_reg       <= fac_next;
            tend_reg      <= tend_next;
            lend_reg      <= lend_next;
            out_valid_reg <= out_valid_next;
        end
        mul_b_reg <= mul_b_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        nanos_reg <= nanos_next;
        tok_reg   <= tok_next;
        tot_reg   <= tot_next;
        inv_reg   <= inv_next;
        fin_reg   <= fin_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign token_nanos = tok_reg;
    assign total_nanos = tot_reg;
    assign invalid     = inv_reg;
    assign is_final    = fin_reg;

endmodule

>>> rtl/duration_string_parser_core.sv
// ----------------------------------------------------------------------------
// Duration string parser core: one character per beat, one result per token.
// Digit, dot and empty beats sustain one per cycle while the back end is idle;
// an s suffix takes one multiply pass, m/h/d two. A closing beat with no suffix
// takes the seconds multiply. Close runs S_END, S_DIV for fraction digits, S_OUT.
// Synchronous aresetn clears parse state, running total, queue and output valid.
// ----------------------------------------------------------------------------
`include "duration_string_parser_core_macros.svh"

module duration_string_parser_core import dsp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // token_end
    input  logic [0:0]   s_tuser,   // [0] list_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] token_nanos, [127:64] total_nanos
    output logic [0:0]   m_tuser,   // [0] invalid
    output logic         m_tlast    // is_final
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             push_valid, push_ready;
    q_entry_t         push_data;
    logic             pop_valid, pop_ready;
    q_entry_t         pop_data;
    logic [CNT_W-1:0] q_count;
    logic             push_fire, pop_fire;

    logic             div_start, div_busy, div_done;
    logic [63:0]      div_dividend, div_divisor, div_quot;

    logic [63:0]      token_nanos, total_nanos;
    logic             invalid, is_final;

    dsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data),
        .count    (q_count)
    );

    dsp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    dsp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .token_nanos  (token_nanos),
        .total_nanos  (total_nanos),
        .invalid      (invalid),
        .is_final     (is_final)
    );

    assign m_tdata    = {total_nanos, token_nanos};
    assign m_tuser[0] = invalid;
    assign m_tlast    = is_final;

    assign push_fire = push_valid && push_ready;
    assign pop_fire  = pop_valid && pop_ready;

    `DSP_ASSERT_NEXT(a_q_count_up, push_fire && !pop_fire, q_count == $past(q_count) + 1'b1, "queue count missed a push")
    `DSP_ASSERT_NEXT(a_q_count_down, pop_fire && !push_fire, q_count == $past(q_count) - 1'b1, "queue count missed a pop")
    `DSP_ASSERT_HOLDS(a_q_count_bound, q_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `DSP_ASSERT_IMPLIES(a_div_start_idle, div_start, !div_busy, "divider started while busy")

endmodule
